// ===== rtl/core/tpsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpsf_pkg
// Shared types and codes of the topic prefix subscription filter.
// ----------------------------------------------------------------------------
package tpsf_pkg;

	localparam int SLOT_COUNT_DEF  = 8;
	localparam int TOPIC_BYTES_DEF = 32;
	localparam int BYTE_W          = 8;
	localparam int OP_W            = 2;
	localparam int STATUS_W        = 2;
	localparam int TOPIC_COUNT_W   = 4;

	localparam logic [OP_W-1:0] OP_SUB   = 2'd0;
	localparam logic [OP_W-1:0] OP_UNSUB = 2'd1;
	localparam logic [OP_W-1:0] OP_MATCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] data_byte;
		logic              has_byte;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic                     accepted;
		logic [TOPIC_COUNT_W-1:0] topic_count;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/core/topic_prefix_subscription_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// topic_prefix_subscription_filter
// Topic prefix table for one subscriber with subscribe, unsubscribe and
// prefix match over byte streams.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall) carries one word per byte of an
//   operation: op, data_byte, has_byte, last. Op code 3 words are taken and
//   dropped. Each operation ends on its word with last set.
//   result channel (result_valid / result_stall) gives one word per ended
//   operation: status, accepted, topic_count.
//   A word is registered on entry with its store row read; from there it is
//   compared against every slot at once and updates the table as it leaves.
//   Its last word forms the result, held in the result register for the port.
//   Throughput is one word per cycle while item_stall is low, set by the
//   single store row read per word.
//   While a result waits under result_stall, words that end no operation
//   keep flowing; a second ending word holds item_stall until the result
//   register frees.
//   Reset empties the table and clears any partial operation; the store
//   needs no clearing pass.
// ----------------------------------------------------------------------------
module topic_prefix_subscription_filter #(
	parameter int SLOT_COUNT  = tpsf_pkg::SLOT_COUNT_DEF,
	parameter int TOPIC_BYTES = tpsf_pkg::TOPIC_BYTES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  item_valid,
	output logic                                       item_stall,
	input  wire logic [tpsf_pkg::OP_W-1:0]             op,
	input  wire logic [tpsf_pkg::BYTE_W-1:0]           data_byte,
	input  wire logic                                  has_byte,
	input  wire logic                                  last,
	output logic                                       result_valid,
	input  wire logic                                  result_stall,
	output logic      [tpsf_pkg::STATUS_W-1:0]         status,
	output logic                                       accepted,
	output logic      [tpsf_pkg::TOPIC_COUNT_W-1:0]    topic_count
);

	localparam int AW = (TOPIC_BYTES > 1) ? $clog2(TOPIC_BYTES) : 1;
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PW = $clog2(TOPIC_BYTES + 1);
	localparam int RW = SLOT_COUNT * tpsf_pkg::BYTE_W;

	logic            acc;
	logic            op_ok;
	logic            adv;
	logic [PW-1:0]   pos_q;
	logic            valid_s1;
	tpsf_pkg::item_t item_s1;
	logic [PW-1:0]   pos_s1;
	logic [RW-1:0]   row_s1;
	tpsf_pkg::res_t  res_next;
	tpsf_pkg::res_t  res_q;
	logic            res_valid_q;
	logic            mem_we;
	logic [AW-1:0]   mem_addr;
	logic [SW-1:0]   mem_lane;
	logic            cp_en;
	logic [SW-1:0]   cp_src;
	logic [SW-1:0]   cp_dst;

	assign op_ok      = (op == tpsf_pkg::OP_SUB) || (op == tpsf_pkg::OP_UNSUB) ||
	                    (op == tpsf_pkg::OP_MATCH);
	assign adv        = valid_s1 && (!item_s1.last || !res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv;
	assign acc        = item_valid && !item_stall;

	// byte position of the next word within its operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (acc && op_ok) begin
			if (last) begin
				pos_q <= '0;
			end else if (has_byte && (pos_q != PW'(TOPIC_BYTES))) begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= op_ok;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1.op        <= op;
			item_s1.data_byte <= data_byte;
			item_s1.has_byte  <= has_byte;
			item_s1.last      <= last;
			pos_s1            <= pos_q;
		end
	end

	tpsf_row_mem #(
		.SLOT_COUNT  (SLOT_COUNT),
		.TOPIC_BYTES (TOPIC_BYTES)
	) u_mem (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (pos_q[AW-1:0]),
		.wr_en   (mem_we),
		.wr_addr (mem_addr),
		.wr_lane (mem_lane),
		.wr_data (item_s1.data_byte),
		.cp_en   (cp_en),
		.cp_src  (cp_src),
		.cp_dst  (cp_dst),
		.rd_row  (row_s1)
	);

	tpsf_table #(
		.SLOT_COUNT  (SLOT_COUNT),
		.TOPIC_BYTES (TOPIC_BYTES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.item     (item_s1),
		.pos      (pos_s1),
		.rd_row   (row_s1),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.mem_lane (mem_lane),
		.cp_en    (cp_en),
		.cp_src   (cp_src),
		.cp_dst   (cp_dst),
		.result   (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && item_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.last) begin
			res_q <= res_next;
		end
	end

	assign result_valid = res_valid_q;
	assign status       = res_q.status;
	assign accepted     = res_q.accepted;
	assign topic_count  = res_q.topic_count;

`ifndef SYNTH
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && item_s1.last && res_valid_q && result_stall))
		else $error("input stalled without a blocked result");

	a_result_follows_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.last) |=> result_valid)
		else $error("ended operation produced no result");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(TOPIC_BYTES))
		else $error("byte position beyond topic length");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status == tpsf_pkg::ST_FULL)) |->
		(topic_count == tpsf_pkg::TOPIC_COUNT_W'(SLOT_COUNT)))
		else $error("full status with table not full");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/tpsf_row_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpsf_row_mem
// Topic byte store, one row per byte position holding that byte of every
// slot; byte-lane write, whole-slot copy, registered read with forwarding.
// ----------------------------------------------------------------------------
module tpsf_row_mem #(
	parameter int SLOT_COUNT  = tpsf_pkg::SLOT_COUNT_DEF,
	parameter int TOPIC_BYTES = tpsf_pkg::TOPIC_BYTES_DEF,
	localparam int AW = (TOPIC_BYTES > 1) ? $clog2(TOPIC_BYTES) : 1,
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  wire logic                                  clk,
	input  wire logic                                  rd_en,
	input  wire logic [AW-1:0]                         rd_addr,
	input  wire logic                                  wr_en,
	input  wire logic [AW-1:0]                         wr_addr,
	input  wire logic [SW-1:0]                         wr_lane,
	input  wire logic [tpsf_pkg::BYTE_W-1:0]           wr_data,
	input  wire logic                                  cp_en,
	input  wire logic [SW-1:0]                         cp_src,
	input  wire logic [SW-1:0]                         cp_dst,
	output logic      [SLOT_COUNT*tpsf_pkg::BYTE_W-1:0] rd_row
);

	localparam int RW = SLOT_COUNT * tpsf_pkg::BYTE_W;
	localparam int BW = tpsf_pkg::BYTE_W;

	logic [RW-1:0] mem_q [TOPIC_BYTES];

	// byte write, or copy of one slot lane over every row
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr][wr_lane*BW +: BW] <= wr_data;
		end else if (cp_en) begin
			for (int r = 0; r < TOPIC_BYTES; r++) begin
				mem_q[r][cp_dst*BW +: BW] <= mem_q[r][cp_src*BW +: BW];
			end
		end
	end

	// read port, a same-cycle write or copy into the row is forwarded
	always_ff @(posedge clk) begin : rd_port
		logic [RW-1:0] fwd_row;
		fwd_row = mem_q[rd_addr];
		if (wr_en && (wr_addr == rd_addr)) begin
			fwd_row[wr_lane*BW +: BW] = wr_data;
		end else if (cp_en) begin
			fwd_row[cp_dst*BW +: BW] = fwd_row[cp_src*BW +: BW];
		end
		if (rd_en) begin
			rd_row <= fwd_row;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/tpsf_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpsf_table
// Subscription table state: lengths, per-slot compare flags and the
// end-of-operation update that forms each result.
// ----------------------------------------------------------------------------
module tpsf_table #(
	parameter int SLOT_COUNT  = tpsf_pkg::SLOT_COUNT_DEF,
	parameter int TOPIC_BYTES = tpsf_pkg::TOPIC_BYTES_DEF,
	localparam int AW = (TOPIC_BYTES > 1) ? $clog2(TOPIC_BYTES) : 1,
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
	localparam int PW = $clog2(TOPIC_BYTES + 1)
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   adv,
	input  wire tpsf_pkg::item_t                        item,
	input  wire logic [PW-1:0]                          pos,
	input  wire logic [SLOT_COUNT*tpsf_pkg::BYTE_W-1:0] rd_row,
	output logic                                        mem_we,
	output logic      [AW-1:0]                          mem_addr,
	output logic      [SW-1:0]                          mem_lane,
	output logic                                        cp_en,
	output logic      [SW-1:0]                          cp_src,
	output logic      [SW-1:0]                          cp_dst,
	output tpsf_pkg::res_t                              result
);

	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int BW = tpsf_pkg::BYTE_W;

	logic [CW-1:0]         count_q;
	logic [SLOT_COUNT-1:0] eq_q;
	logic                  over_q;
	logic [PW-1:0]         len_q [SLOT_COUNT];

	logic                  overlong;
	logic                  take;
	logic                  full;
	logic [PW-1:0]         end_pos;
	logic                  over_eff;
	logic [SLOT_COUNT-1:0] clear;
	logic [SLOT_COUNT-1:0] eq_eff;
	logic [SLOT_COUNT-1:0] hit_u;
	logic [SLOT_COUNT-1:0] hit_m;
	logic                  found;
	logic [SW-1:0]         idx;
	logic [CW-1:0]         tail_c;
	logic [SW-1:0]         tail;
	logic [SW-1:0]         cidx;
	logic [CW-1:0]         count_next;
	logic [tpsf_pkg::STATUS_W-1:0] status;
	logic                  accepted;

	assign overlong = (pos == PW'(TOPIC_BYTES));
	assign take     = item.has_byte && !overlong;
	assign full     = (count_q == CW'(SLOT_COUNT));
	assign end_pos  = take ? PW'(pos + PW'(1)) : pos;
	assign over_eff = over_q || (item.has_byte && overlong);
	assign tail_c   = count_q - CW'(1);
	assign tail     = tail_c[SW-1:0];
	assign cidx     = count_q[SW-1:0];

	assign mem_we   = adv && take && (item.op == tpsf_pkg::OP_SUB) && !full;
	assign mem_addr = pos[AW-1:0];
	assign mem_lane = cidx;

	// removal moves the tail entry into the freed slot
	assign cp_en  = adv && item.last && (item.op == tpsf_pkg::OP_UNSUB) && !over_eff && found;
	assign cp_src = tail;
	assign cp_dst = idx;

	// per slot compare of this byte
	always_comb begin
		for (int j = 0; j < SLOT_COUNT; j++) begin
			if (!take || (item.op == tpsf_pkg::OP_SUB)) begin
				clear[j] = 1'b0;
			end else if (pos >= len_q[j]) begin
				clear[j] = (item.op == tpsf_pkg::OP_UNSUB);
			end else begin
				clear[j] = (rd_row[j*BW +: BW] != item.data_byte);
			end
		end
	end

	assign eq_eff = eq_q & ~clear;

	// per held entry hits
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			hit_u[i] = (CW'(i) < count_q) && eq_eff[i] && (len_q[i] == end_pos);
			hit_m[i] = (CW'(i) < count_q) && eq_eff[i] && (len_q[i] <= end_pos);
		end
	end

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (hit_u[i]) begin
				found = 1'b1;
				idx   = SW'(i);
			end
		end
	end

	always_comb begin
		count_next = count_q;
		status     = tpsf_pkg::ST_OK;
		accepted   = 1'b0;
		unique case (item.op)
			tpsf_pkg::OP_SUB: begin
				if (over_eff) begin
					status = tpsf_pkg::ST_TOO_LONG;
				end else if (full) begin
					status = tpsf_pkg::ST_FULL;
				end else begin
					count_next = count_q + CW'(1);
				end
			end
			tpsf_pkg::OP_UNSUB: begin
				if (!over_eff && found) begin
					count_next = tail_c;
				end else begin
					status = tpsf_pkg::ST_NOT_FOUND;
				end
			end
			tpsf_pkg::OP_MATCH: begin
				accepted = |hit_m;
			end
			default: begin
			end
		endcase
	end

	assign result.status      = status;
	assign result.accepted    = accepted;
	assign result.topic_count = tpsf_pkg::TOPIC_COUNT_W'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			eq_q    <= '1;
			over_q  <= 1'b0;
		end else if (adv) begin
			if (item.last) begin
				count_q <= count_next;
				eq_q    <= '1;
				over_q  <= 1'b0;
			end else begin
				eq_q   <= eq_eff;
				over_q <= over_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cp_en) begin
			len_q[idx] <= len_q[tail];
		end else if (adv && item.last && (item.op == tpsf_pkg::OP_SUB) && !over_eff && !full) begin
			len_q[cidx] <= end_pos;
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_topic_prefix_subscription_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_topic_prefix_subscription_filter
// Self-checking bench for the topic prefix filter. Subscribe, unsubscribe and
// match words stream in bursts. The result port stalls on a pattern of its
// own. A shadow table in the scoreboard predicts the status, the match flag
// and the topic count of every finished operation.
// ----------------------------------------------------------------------------
module tb_topic_prefix_subscription_filter;

	localparam int SLOTS       = tpsf_pkg::SLOT_COUNT_DEF;
	localparam int TBYTES      = tpsf_pkg::TOPIC_BYTES_DEF;
	localparam int POOL        = 12;
	localparam int WORD_TARGET = 550;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [tpsf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	class filter_scoreboard;
		logic [7:0]         topic_bytes [SLOTS][TBYTES];
		logic [5:0]         slot_len [SLOTS];
		logic [3:0]         held;
		logic [5:0]         pos;
		logic [SLOTS-1:0]   still_equal;
		bit                 overlong;
		tpsf_pkg::res_t     due_results [$];
		int                 errors;
		int                 ops_done;
		int                 status_seen [4];
		int                 matches_accepted;

		function new();
			for (int i = 0; i < SLOTS; i++) slot_len[i] = '0;
			held = '0;
			pos = '0;
			still_equal = '1;
			overlong = 1'b0;
		endfunction

		function void take_word(tpsf_pkg::item_t w);
			tpsf_pkg::res_t r;
			int tail;
			bit beyond;
			bit differs;
			if (w.op == OP_UNUSED) return;
			if (w.has_byte) begin
				if (pos >= TBYTES) begin
					overlong = 1'b1;
				end else begin
					if (w.op == tpsf_pkg::OP_SUB) begin
						if (held < SLOTS) topic_bytes[held][pos] = w.data_byte;
					end else begin
						for (int i = 0; i < SLOTS; i++) begin
							beyond = pos >= slot_len[i];
							differs = !beyond && topic_bytes[i][pos] != w.data_byte;
							if (differs || (w.op == tpsf_pkg::OP_UNSUB && beyond))
								still_equal[i] = 1'b0;
						end
					end
					pos++;
				end
			end
			if (!w.last) return;
			r.status = tpsf_pkg::ST_OK;
			r.accepted = 1'b0;
			case (w.op)
				tpsf_pkg::OP_SUB: begin
					if (overlong) r.status = tpsf_pkg::ST_TOO_LONG;
					else if (held >= SLOTS) r.status = tpsf_pkg::ST_FULL;
					else begin
						slot_len[held] = pos;
						held++;
					end
				end
				tpsf_pkg::OP_UNSUB: begin
					r.status = tpsf_pkg::ST_NOT_FOUND;
					for (int i = 0; i < held; i++) begin
						if (!overlong && still_equal[i] && slot_len[i] == pos) begin
							tail = held - 1;
							for (int k = 0; k < TBYTES; k++)
								topic_bytes[i][k] = topic_bytes[tail][k];
							slot_len[i] = slot_len[tail];
							held = tail;
							r.status = tpsf_pkg::ST_OK;
							break;
						end
					end
				end
				default: begin
					for (int i = 0; i < held; i++) begin
						if (still_equal[i] && slot_len[i] <= pos) begin
							r.accepted = 1'b1;
							break;
						end
					end
				end
			endcase
			r.topic_count = held;
			due_results.push_back(r);
			ops_done++;
			status_seen[r.status]++;
			if (r.accepted) matches_accepted++;
			pos = '0;
			still_equal = '1;
			overlong = 1'b0;
		endfunction

		function void compare_result(logic [tpsf_pkg::STATUS_W-1:0] st, logic acc,
				logic [tpsf_pkg::TOPIC_COUNT_W-1:0] cnt);
			tpsf_pkg::res_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result word: status %0d accepted %0d topic_count %0d",
					st, acc, cnt);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (st !== want.status) begin
				$error("status expected %0d got %0d", want.status, st);
				errors++;
			end
			if (acc !== want.accepted) begin
				$error("accepted expected %0d got %0d", want.accepted, acc);
				errors++;
			end
			if (cnt !== want.topic_count) begin
				$error("topic_count expected %0d got %0d", want.topic_count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               item_valid = 1'b0;
	logic                               item_stall;
	logic [tpsf_pkg::OP_W-1:0]          op = tpsf_pkg::OP_SUB;
	logic [tpsf_pkg::BYTE_W-1:0]        data_byte = '0;
	logic                               has_byte = 1'b0;
	logic                               last = 1'b0;
	logic                               result_valid;
	logic                               result_stall = 1'b0;
	logic [tpsf_pkg::STATUS_W-1:0]      status;
	logic                               accepted;
	logic [tpsf_pkg::TOPIC_COUNT_W-1:0] topic_count;

	filter_scoreboard sb;
	int unsigned      cycle_count = 0;
	int               burst_left = 0;
	int               words_sent = 0;
	int               noise_sent = 0;
	int               rx_mode = 0;
	int               rx_timer = 0;
	int               rx_hold = 0;
	logic [7:0]       pool_bytes [POOL][48];
	int               pool_len [POOL];
	logic [7:0]       op_bytes [64];

	topic_prefix_subscription_filter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.accepted     (accepted),
		.topic_count  (topic_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("topic_prefix_subscription_filter verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.compare_result(status, accepted, topic_count);
	end

	// result side: free running, coin flip, or occasional long holds
	always @(negedge clk) begin
		if (rx_timer == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_timer = $urandom_range(20, 120);
		end else begin
			rx_timer--;
		end
		if (rx_hold > 0) begin
			result_stall <= 1'b1;
			rx_hold--;
		end else if (rx_mode == 1) begin
			result_stall <= ($urandom_range(0, 1) == 0);
		end else if (rx_mode >= 2 && $urandom_range(0, 11) == 0) begin
			result_stall <= 1'b1;
			rx_hold = $urandom_range(2, 24);
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic logic [7:0] topic_char();
		int k;
		k = $urandom_range(0, 7);
		case (k)
			0: return 8'h00;
			1: return 8'hff;
			6, 7: return 8'($urandom_range(0, 255));
			default: return 8'h61 + 8'(k - 2);
		endcase
	endfunction

	function automatic void fresh_topic(input int idx);
		int len;
		case ($urandom_range(0, 15))
			0: len = 0;
			1: len = TBYTES;
			2: len = TBYTES + 1;
			3: len = TBYTES - 1;
			4: len = 40;
			default: len = $urandom_range(1, 5);
		endcase
		pool_len[idx] = len;
		for (int k = 0; k < len; k++) pool_bytes[idx][k] = topic_char();
	endfunction

	task automatic push_word(input tpsf_pkg::item_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				item_valid <= 1'b0;
			end
		end
		@(negedge clk);
		item_valid <= 1'b1;
		op <= w.op;
		data_byte <= w.data_byte;
		has_byte <= w.has_byte;
		last <= w.last;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.take_word(w);
		burst_left--;
		if (w.op == OP_UNUSED) noise_sent++;
		else words_sent++;
	endtask

	// bytes come from op_bytes; scramble adds empty words, unused-op words
	// and, for unsubscribe and match, bytes under other op codes
	task automatic send_op(input logic [tpsf_pkg::OP_W-1:0] kind, input int nbytes,
			input bit scramble);
		tpsf_pkg::item_t w;
		bit mix;
		bit tail_word;
		mix = scramble && kind != tpsf_pkg::OP_SUB && $urandom_range(0, 7) == 0;
		tail_word = nbytes == 0 || (scramble && $urandom_range(0, 5) == 0);
		for (int i = 0; i < nbytes; i++) begin
			if (scramble && $urandom_range(0, 7) == 0) begin
				w.op = tpsf_pkg::OP_W'($urandom_range(0, 2));
				w.data_byte = 8'($urandom_range(0, 255));
				w.has_byte = 1'b0;
				w.last = 1'b0;
				push_word(w);
			end
			if (scramble && $urandom_range(0, 19) == 0) begin
				w.op = OP_UNUSED;
				w.data_byte = 8'($urandom_range(0, 255));
				w.has_byte = 1'($urandom_range(0, 1));
				w.last = 1'($urandom_range(0, 1));
				push_word(w);
			end
			w.op = (mix && $urandom_range(0, 3) == 0) ?
				tpsf_pkg::OP_W'($urandom_range(0, 2)) : kind;
			w.data_byte = op_bytes[i];
			w.has_byte = 1'b1;
			w.last = !tail_word && i == nbytes - 1;
			push_word(w);
		end
		if (tail_word) begin
			w.op = kind;
			w.data_byte = 8'($urandom_range(0, 255));
			w.has_byte = 1'b0;
			w.last = 1'b1;
			push_word(w);
		end
	endtask

	initial begin
		tpsf_pkg::item_t           w;
		logic [tpsf_pkg::OP_W-1:0] kind;
		int         p, n, idx, pick, shape, target, mode, op_total;
		int         sub_cut, unsub_cut;
		sb = new();
		mode = 0;
		op_total = 0;
		for (int k = 0; k < POOL; k++) fresh_topic(k);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, empty topics, prefixes, unused op, mixed op codes
		send_op(tpsf_pkg::OP_MATCH, 0, 1'b0);
		send_op(tpsf_pkg::OP_UNSUB, 0, 1'b0);
		op_bytes[0] = 8'h61;
		op_bytes[1] = 8'h62;
		send_op(tpsf_pkg::OP_SUB, 2, 1'b0);
		op_bytes[2] = 8'h63;
		send_op(tpsf_pkg::OP_MATCH, 3, 1'b0);
		send_op(tpsf_pkg::OP_MATCH, 1, 1'b0);
		send_op(tpsf_pkg::OP_SUB, 0, 1'b0);
		send_op(tpsf_pkg::OP_MATCH, 0, 1'b0);
		send_op(tpsf_pkg::OP_UNSUB, 0, 1'b0);
		w = '{op: OP_UNUSED, data_byte: 8'h5a, has_byte: 1'b1, last: 1'b1};
		push_word(w);
		op_bytes[0] = 8'h00;
		op_bytes[1] = 8'hff;
		send_op(tpsf_pkg::OP_SUB, 2, 1'b0);
		op_bytes[2] = 8'h80;
		send_op(tpsf_pkg::OP_MATCH, 3, 1'b0);
		op_bytes[0] = 8'h61;
		op_bytes[1] = 8'h62;
		send_op(tpsf_pkg::OP_UNSUB, 2, 1'b0);
		op_bytes[0] = 8'h00;
		op_bytes[1] = 8'hfe;
		send_op(tpsf_pkg::OP_UNSUB, 2, 1'b0);
		w = '{op: tpsf_pkg::OP_UNSUB, data_byte: 8'h00, has_byte: 1'b1, last: 1'b0};
		push_word(w);
		w = '{op: tpsf_pkg::OP_MATCH, data_byte: 8'hff, has_byte: 1'b1, last: 1'b1};
		push_word(w);

		// run the table into full
		for (int k = 0; k < 9; k++) begin
			op_bytes[0] = topic_char();
			send_op(tpsf_pkg::OP_SUB, 1, 1'b1);
		end

		while (words_sent < WORD_TARGET) begin
			if (op_total % 16 == 0) mode = $urandom_range(0, 2);
			sub_cut = (mode == 0) ? 60 : (mode == 1) ? 15 : 34;
			unsub_cut = (mode == 0) ? 75 : (mode == 1) ? 65 : 67;
			pick = $urandom_range(0, 99);
			kind = (pick < sub_cut) ? tpsf_pkg::OP_SUB :
				(pick < unsub_cut) ? tpsf_pkg::OP_UNSUB : tpsf_pkg::OP_MATCH;
			p = $urandom_range(0, POOL - 1);
			n = pool_len[p];
			for (int k = 0; k < n; k++) op_bytes[k] = pool_bytes[p][k];
			if (kind == tpsf_pkg::OP_UNSUB && n > 0 && $urandom_range(0, 5) == 0) begin
				idx = $urandom_range(0, n - 1);
				op_bytes[idx] = op_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
			end
			if (kind == tpsf_pkg::OP_MATCH) begin
				shape = $urandom_range(0, 9);
				if (shape == 0) begin
					n = $urandom_range(0, 6);
					for (int k = 0; k < n; k++) op_bytes[k] = 8'($urandom_range(0, 255));
				end else if (shape == 1 && n > 0) begin
					n = $urandom_range(0, n - 1);
				end else begin
					target = (shape == 2) ? $urandom_range((n > 30) ? n : 30, 48)
						: n + $urandom_range(0, 4);
					for (int k = n; k < target; k++) op_bytes[k] = topic_char();
					n = target;
				end
			end
			send_op(kind, n, 1'b1);
			op_total++;
			if ($urandom_range(0, 15) == 0) fresh_topic($urandom_range(0, POOL - 1));
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d words (%0d unused-op words), %0d operations finished",
			words_sent, noise_sent, sb.ops_done);
		$display("status ok/too long/full/not found: %0d/%0d/%0d/%0d, matches accepted: %0d",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
			sb.matches_accepted);
		if (sb.errors == 0)
			$display("topic_prefix_subscription_filter verification clean");
		else
			$display("topic_prefix_subscription_filter verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/tpsf_pkg.sv
rtl/core/tpsf_row_mem.sv
rtl/core/tpsf_table.sv
rtl/core/topic_prefix_subscription_filter.sv
tb/tb_topic_prefix_subscription_filter.sv
